### rtl/imsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imsu_pkg;

  localparam int OP_W       = 3;
  localparam int SITE_W     = 10;
  localparam int SLOT_W     = 4;
  localparam int BOND_W     = 8;
  localparam int CPL_W      = 16;
  localparam int TOTAL_W    = 5;
  localparam int UNI_W      = 32;
  localparam int ENERGY_W   = 48;
  localparam int DE_OUT_W   = 22;
  localparam int COUNT_W    = 32;
  localparam int BETA_W     = 16;

  localparam logic [OP_W-1:0] OP_LOAD_COUPLING = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_NEIGHBOR = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_SITE     = 3'd2;
  localparam logic [OP_W-1:0] OP_VISIT         = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD_ENERGY   = 3'd4;

  localparam logic [BETA_W-1:0] BETA_RESET = 16'd4096;

  localparam int EXP_P_W      = 25;
  localparam int EXP_K_W      = 6;
  localparam int FRAC_SHIFT   = 36;
  localparam int OUT_SHIFT    = 24;
  localparam int TAYLOR_TERMS = 24;
  localparam logic [EXP_P_W-1:0] EXP_P_LIMIT = 25'h170_0000;
  localparam logic [55:0] LN2_Q56 = 56'hB17217F7D1CF7A;

  typedef logic [EXP_P_W-1:0] exp_p_t;
  typedef logic [UNI_W-1:0]   prob_t;

endpackage

`default_nettype wire

### rtl/ising_metropolis_site_update.sv
// Metropolis single-spin-flip engine for an Ising lattice. Load beats (coupling, neighbor
// entry, site, energy) are taken in idle and written in the execute state. A visit reads
// the site's spin and neighbor count, then streams the neighbor list through the
// neighbor, spin and coupling memories, one neighbor a cycle, reading the neighbor memory
// and then the spin and coupling memories ahead of the field sum. A change that is not
// positive is accepted at once; one whose product with beta reaches the exponent limit is
// rejected. Otherwise the acceptance test runs through a shared 32x32 multiplier and an
// 8-bit-a-cycle divider that evaluate the exponential series, up to 24 terms, after range
// reduction by ln 2. One beat is worked on at a time, and the next one is taken while the
// last result still waits on the output.
`timescale 1ns / 1ps
`default_nettype none

module ising_metropolis_site_update #(
  parameter int MAX_SITES     = 1024,
  parameter int MAX_NEIGHBORS = 16,
  parameter int MAX_BONDS     = 256
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic [imsu_pkg::BETA_W-1:0]             cfg_wr_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [imsu_pkg::OP_W-1:0]               op,
  input  logic [imsu_pkg::SITE_W-1:0]             site,
  input  logic [imsu_pkg::SLOT_W-1:0]             slot,
  input  logic [imsu_pkg::SITE_W-1:0]             other_site,
  input  logic [imsu_pkg::BOND_W-1:0]             bond,
  input  logic signed [imsu_pkg::CPL_W-1:0]       coupling,
  input  logic                                    spin_up,
  input  logic [imsu_pkg::TOTAL_W-1:0]            neighbor_total,
  input  logic                                    proposed_up,
  input  logic [imsu_pkg::UNI_W-1:0]              uniform,
  input  logic signed [imsu_pkg::ENERGY_W-1:0]    energy_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    accepted,
  output logic                                    spin_now,
  output logic signed [imsu_pkg::DE_OUT_W-1:0]    delta_energy,
  output logic signed [imsu_pkg::ENERGY_W-1:0]    total_energy,
  output logic [imsu_pkg::COUNT_W-1:0]            accept_total
);
  import imsu_pkg::*;

  localparam int SW  = $clog2(MAX_SITES);
  localparam int NW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int BW  = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;
  localparam int CW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int NAW = (MAX_SITES * MAX_NEIGHBORS > 1) ? $clog2(MAX_SITES * MAX_NEIGHBORS) : 1;
  localparam int FW  = CPL_W + CW;
  localparam int DEW = FW + 1;
  localparam int PW  = BETA_W + DEW - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_CNT, S_RUN, S_DE, S_CHK, S_PROD, S_EXPW, S_OUT
  } state_t;

  function automatic logic [31:0] reduce_mod(input logic [31:0] x, input logic [31:0] m);
    logic [47:0] rv;
    logic [47:0] s;
    rv = 48'(x);
    for (int j = SITE_W - 1; j >= 0; j--) begin
      s = 48'(m) << j;
      if (rv >= s) begin
        rv = rv - s;
      end
    end
    return rv[31:0];
  endfunction

  state_t                    state;
  logic [BETA_W-1:0]         beta;
  logic [ENERGY_W-1:0]       energy;
  logic [COUNT_W-1:0]        accept_count;

  logic [OP_W-1:0]           op_r;
  logic [SW-1:0]             site_r;
  logic [NW-1:0]             slot_r;
  logic [SW-1:0]             other_r;
  logic [BW-1:0]             bond_r;
  logic signed [CPL_W-1:0]   coupling_r;
  logic                      spin_up_r;
  logic [CW-1:0]             total_r;
  logic                      prop_r;
  logic [UNI_W-1:0]          uni_r;
  logic [ENERGY_W-1:0]       energy_value_r;

  logic                      cur_r;
  logic [CW-1:0]             cnt_r;
  logic [CW-1:0]             issue_idx;
  logic                      p1;
  logic                      p2;
  logic signed [FW-1:0]      field;
  logic signed [DEW-1:0]     de;
  logic [PW-1:0]             prod_p;
  logic                      acc_r;
  logic                      exp_start;
  logic                      exp_done;
  prob_t                     exp_value;

  logic                      spin_mem [MAX_SITES];
  logic [CW-1:0]             cnt_mem  [MAX_SITES];
  logic [SW+BW-1:0]          nb_mem   [MAX_SITES*MAX_NEIGHBORS];
  logic signed [CPL_W-1:0]   cpl_mem  [MAX_BONDS];

  logic                      spin_q;
  logic [CW-1:0]             cnt_q;
  logic [SW+BW-1:0]          nb_q;
  logic signed [CPL_W-1:0]   cpl_q;

  logic                      spin_we;
  logic [SW-1:0]             spin_wa;
  logic                      spin_wd;
  logic                      spin_re;
  logic [SW-1:0]             spin_ra;
  logic                      visit_head;
  logic [NAW-1:0]            nb_base;
  logic                      issue_ok;
  logic                      out_free;
  logic signed [FW-1:0]      cpl_ext;
  logic signed [DEW-1:0]     f2;
  logic signed [DEW-1:0]     de_calc;
  logic [ENERGY_W-1:0]       de48;
  logic [ENERGY_W-1:0]       energy_sum;
  logic [SW-1:0]             site_red;
  logic [NW-1:0]             slot_red;
  logic [SW-1:0]             other_red;
  logic [BW-1:0]             bond_red;
  logic [CW-1:0]             total_sat;

  assign in_ready   = state == S_IDLE;
  assign out_free   = !out_valid || out_ready;
  assign visit_head = state == S_EXEC && op_r == OP_VISIT;
  assign issue_ok   = issue_idx < cnt_r;
  assign nb_base    = NAW'(site_r) * NAW'(MAX_NEIGHBORS);
  assign cpl_ext    = FW'(cpl_q);
  assign f2         = {field, 1'b0};
  assign de_calc    = (prop_r != cur_r) ? (prop_r ? -f2 : f2) : '0;
  assign de48       = ENERGY_W'(de);
  assign energy_sum = energy + de48;

  assign site_red  = SW'(reduce_mod(32'(site), 32'(MAX_SITES)));
  assign other_red = SW'(reduce_mod(32'(other_site), 32'(MAX_SITES)));
  assign slot_red  = NW'(reduce_mod(32'(slot), 32'(MAX_NEIGHBORS)));
  assign bond_red  = BW'(reduce_mod(32'(bond), 32'(MAX_BONDS)));
  assign total_sat = (32'(neighbor_total) > 32'(MAX_NEIGHBORS)) ?
                     CW'(MAX_NEIGHBORS) : CW'(neighbor_total);

  always_comb begin
    spin_we = 1'b0;
    spin_wa = site_r;
    spin_wd = spin_up_r;
    if (state == S_EXEC && op_r == OP_LOAD_SITE) begin
      spin_we = 1'b1;
    end else if (state == S_OUT && out_free && acc_r) begin
      spin_we = 1'b1;
      spin_wd = prop_r;
    end
  end

  assign spin_re = visit_head || (state == S_RUN && p1);
  assign spin_ra = visit_head ? site_r : nb_q[SW+BW-1:BW];

  always_ff @(posedge clk) begin
    if (spin_we) begin
      spin_mem[spin_wa] <= spin_wd;
    end
    if (spin_re) begin
      spin_q <= spin_mem[spin_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && op_r == OP_LOAD_SITE) begin
      cnt_mem[site_r] <= total_r;
    end
    if (visit_head) begin
      cnt_q <= cnt_mem[site_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && op_r == OP_LOAD_NEIGHBOR) begin
      nb_mem[nb_base + NAW'(slot_r)] <= {other_r, bond_r};
    end
    if (state == S_RUN && issue_ok) begin
      nb_q <= nb_mem[nb_base + NAW'(issue_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && op_r == OP_LOAD_COUPLING) begin
      cpl_mem[bond_r] <= coupling_r;
    end
    if (state == S_RUN && p1) begin
      cpl_q <= cpl_mem[nb_q[BW-1:0]];
    end
  end

  imsu_exp u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .p     (EXP_P_W'(prod_p)),
    .done  (exp_done),
    .value (exp_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      energy       <= '0;
      accept_count <= '0;
      beta         <= BETA_RESET;
      exp_start    <= 1'b0;
      p1           <= 1'b0;
      p2           <= 1'b0;
    end else begin
      exp_start <= 1'b0;
      if (cfg_wr_en) begin
        beta <= cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r           <= op;
            site_r         <= site_red;
            slot_r         <= slot_red;
            other_r        <= other_red;
            bond_r         <= bond_red;
            coupling_r     <= coupling;
            spin_up_r      <= spin_up;
            total_r        <= total_sat;
            prop_r         <= proposed_up;
            uni_r          <= uniform;
            energy_value_r <= energy_value;
            state          <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (op_r == OP_LOAD_ENERGY) begin
            energy <= energy_value_r;
          end
          state <= (op_r == OP_VISIT) ? S_CNT : S_IDLE;
        end
        S_CNT: begin
          cur_r     <= spin_q;
          cnt_r     <= cnt_q;
          issue_idx <= '0;
          p1        <= 1'b0;
          p2        <= 1'b0;
          field     <= '0;
          state     <= S_RUN;
        end
        S_RUN: begin
          p1 <= issue_ok;
          p2 <= p1;
          if (issue_ok) begin
            issue_idx <= issue_idx + CW'(1);
          end
          if (p2) begin
            field <= field + (spin_q ? cpl_ext : -cpl_ext);
          end
          if (!issue_ok && !p1 && !p2) begin
            state <= S_DE;
          end
        end
        S_DE: begin
          de    <= de_calc;
          state <= S_CHK;
        end
        S_CHK: begin
          if (de[DEW-1] || de == '0) begin
            acc_r <= 1'b1;
            state <= S_OUT;
          end else begin
            prod_p <= PW'(beta) * PW'(de[DEW-2:0]);
            state  <= S_PROD;
          end
        end
        S_PROD: begin
          if (prod_p >= PW'(EXP_P_LIMIT)) begin
            acc_r <= 1'b0;
            state <= S_OUT;
          end else begin
            exp_start <= 1'b1;
            state     <= S_EXPW;
          end
        end
        S_EXPW: begin
          if (exp_done) begin
            acc_r <= exp_value > uni_r;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            accepted     <= acc_r;
            spin_now     <= acc_r ? prop_r : cur_r;
            delta_energy <= de48[DE_OUT_W-1:0];
            total_energy <= acc_r ? energy_sum : energy;
            accept_total <= acc_r ? accept_count + COUNT_W'(1) : accept_count;
            if (acc_r) begin
              energy       <= energy_sum;
              accept_count <= accept_count + COUNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> issue_idx <= cnt_r)
    else $error("Neighbor issue index ran past the count.");

  a_exp_done: assert property (@(posedge clk) disable iff (rst)
    exp_done |-> state == S_EXPW)
    else $error("Exponential result arrived outside the wait state.");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && out_free |=>
      out_valid && accept_count == $past(accept_count) + COUNT_W'(accepted))
    else $error("Acceptance count does not follow the result beat.");

endmodule

`default_nettype wire

### rtl/imsu_exp.sv
`timescale 1ns / 1ps
`default_nettype none

module imsu_exp (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  imsu_pkg::exp_p_t p,
  output logic             done,
  output imsu_pkg::prob_t  value
);
  import imsu_pkg::*;

  typedef enum logic [2:0] {E_IDLE, E_RED, E_MUL, E_DIV, E_FIN} e_state_t;

  e_state_t       e_state;
  logic [61:0]    x;
  logic [EXP_K_W-1:0] k;
  logic [2:0]     bit_sel;
  logic [55:0]    r;
  logic [56:0]    t;
  logic [57:0]    acc;
  logic [4:0]     n;
  logic [2:0]     mstep;
  logic [63:0]    prod;
  logic [113:0]   macc;
  logic [63:0]    dq;
  logic [4:0]     rem;
  logic [2:0]     dstep;

  logic [61:0]    l_sh;
  logic           x_ge;
  logic [61:0]    x_red;
  logic [31:0]    ma;
  logic [31:0]    mb;
  logic [113:0]   prod_sh;
  logic [113:0]   macc_sum;
  logic [63:0]    d_w;
  logic [4:0]     r_w;
  logic [5:0]     r2;
  logic [6:0]     sh;
  logic [57:0]    v;

  assign l_sh  = 62'(LN2_Q56) << bit_sel;
  assign x_ge  = x >= l_sh;
  assign x_red = x_ge ? x - l_sh : x;

  always_comb begin
    unique case (mstep)
      3'd0: begin
        ma = t[31:0];
        mb = r[31:0];
      end
      3'd1: begin
        ma = t[31:0];
        mb = {8'b0, r[55:32]};
      end
      3'd2: begin
        ma = {7'b0, t[56:32]};
        mb = r[31:0];
      end
      3'd3: begin
        ma = {7'b0, t[56:32]};
        mb = {8'b0, r[55:32]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    unique case (mstep)
      3'd2, 3'd3: prod_sh = 114'(prod) << 32;
      3'd4:       prod_sh = 114'(prod) << 64;
      default:    prod_sh = 114'(prod);
    endcase
  end

  assign macc_sum = macc + prod_sh;

  always_comb begin
    d_w = dq;
    r_w = rem;
    r2  = '0;
    for (int i = 0; i < 8; i++) begin
      r2  = {r_w, d_w[63]};
      d_w = {d_w[62:0], 1'b0};
      if (r2 >= {1'b0, n}) begin
        r2     = r2 - {1'b0, n};
        d_w[0] = 1'b1;
      end
      r_w = r2[4:0];
    end
  end

  assign sh = 7'(OUT_SHIFT) + 7'(k);
  assign v  = acc >> sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_state <= E_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (e_state)
        E_IDLE: begin
          if (start) begin
            x       <= 62'(p) << FRAC_SHIFT;
            k       <= '0;
            bit_sel <= 3'(EXP_K_W - 1);
            e_state <= E_RED;
          end
        end
        E_RED: begin
          x          <= x_red;
          k[bit_sel] <= x_ge;
          if (bit_sel == 3'd0) begin
            r       <= x_red[55:0];
            t       <= 57'(1) << 56;
            acc     <= 58'(1) << 56;
            n       <= 5'd1;
            mstep   <= '0;
            macc    <= '0;
            e_state <= E_MUL;
          end else begin
            bit_sel <= bit_sel - 3'd1;
          end
        end
        E_MUL: begin
          if (mstep != 3'd4) begin
            prod <= 64'(ma) * 64'(mb);
          end
          if (mstep != 3'd0) begin
            macc <= macc_sum;
          end
          if (mstep == 3'd4) begin
            dq      <= {6'b0, macc_sum[113:56]};
            rem     <= '0;
            dstep   <= '0;
            e_state <= E_DIV;
          end else begin
            mstep <= mstep + 3'd1;
          end
        end
        E_DIV: begin
          dq  <= d_w;
          rem <= r_w;
          if (dstep == 3'd7) begin
            t   <= d_w[56:0];
            acc <= n[0] ? acc - 58'(d_w[56:0]) : acc + 58'(d_w[56:0]);
            n   <= n + 5'd1;
            if (n == 5'(TAYLOR_TERMS) || d_w[56:0] == '0) begin
              e_state <= E_FIN;
            end else begin
              mstep   <= '0;
              macc    <= '0;
              e_state <= E_MUL;
            end
          end else begin
            dstep <= dstep + 3'd1;
          end
        end
        E_FIN: begin
          value   <= (|v[57:32]) ? '1 : v[31:0];
          done    <= 1'b1;
          e_state <= E_IDLE;
        end
        default: e_state <= E_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> e_state == E_IDLE)
    else $error("Exponential unit started while busy.");

  a_div_term: assert property (@(posedge clk) disable iff (rst)
    e_state == E_DIV |-> n != 5'd0 && n <= 5'(TAYLOR_TERMS))
    else $error("Series term index out of range.");

  a_mul_step: assert property (@(posedge clk) disable iff (rst)
    e_state == E_MUL |-> mstep <= 3'd4)
    else $error("Partial product step out of range.");

endmodule

`default_nettype wire
